FILE: rtl/core/capture_record_checker_assert.svh
// Assertion macros for the capture record checker.
// Modules that include this header must provide clk_i and rst_ni.
`ifndef CAPTURE_RECORD_CHECKER_ASSERT_SVH
`define CAPTURE_RECORD_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CRC_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define CRC_ASSERT(lbl, prop)
`define CRC_NEVER(lbl, prop)
`endif
`endif

FILE: rtl/core/crc_chk_pkg.sv
// Shared types, constants and CRC functions for the capture record checker.
// No dependencies.
package crc_chk_pkg;

  localparam int unsigned FixedBytes = 20;
  localparam logic [8:0] PosMax = 9'd511;
  localparam logic [10:0] HcrcPoly = 11'h385;
  localparam logic [10:0] HcrcInit = 11'h01A;
  localparam logic [23:0] FcrcPoly = 24'h5D6DCB;
  localparam logic [23:0] FcrcInit = 24'hFEDCBA;
  localparam logic [7:0] FlagMask = 8'h0F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_CHAN  = 3'd3,
    ST_HDR_CRC   = 3'd4,
    ST_FRAME_CRC = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_SLOT_LIMIT  = 2'd1,
    CFG_MAX_CYCLE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]  pos;
    logic [7:0]  channel;
    logic [7:0]  flags;
    logic [7:0]  cycle;
    logic [15:0] slot;
    logic [15:0] len;
    logic [63:0] stamp;
    logic [10:0] exp_hcrc;
    logic [10:0] rcv_hcrc;
    logic [23:0] run_fcrc;
    logic [23:0] rcv_fcrc;
  } rec_t;

  function automatic logic [10:0] hcrc_byte(logic [10:0] crc_in, logic [7:0] b);
    logic [10:0] c;
    logic fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[10] ^ b[7-i];
      c = {c[9:0], 1'b0};
      if (fb) c = c ^ HcrcPoly;
    end
    return c;
  endfunction

  function automatic logic [23:0] fcrc_byte(logic [23:0] crc_in, logic [7:0] b);
    logic [23:0] c;
    logic hi;
    c = crc_in ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      hi = c[23];
      c = {c[22:0], 1'b0};
      if (hi) c = c ^ FcrcPoly;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/capture_record_checker.sv
// Top level of the capture record checker: front end, queue, back end.
// Uses crc_chk_pkg, crc_chk_front, crc_chk_queue and crc_chk_back.
//
// Channel     Direction  Handshake                  Payload
// s_axis      in         s_axis_tvalid/tready       tdata byte, tlast
// m_axis      out        m_axis_tvalid/tready       tdata result item
// cfg         in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the queue is not full; the CRC update per byte is one unrolled step.
// A result item goes into a two-entry queue when its last byte is taken, then into the registered output.
// Input stalls only when the queue is full; reset is asynchronous, no clearing pass.
module capture_record_checker #(
  parameter int unsigned MAX_PAYLOAD = 254,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_in
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, channel, flags, cycle, slot_id, pay_len, timestamp, hdr_crc,
  // valid_count, malformed_count, header_error_count, frame_error_count
  output logic [263:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i
);

  logic take, push, full, qv, pop;
  crc_chk_pkg::rec_t wrec, rrec;

  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && !full;
  assign cfg_ready_o   = 1'b1;

  crc_chk_front u_front (
    .clk_i, .rst_ni, .take_i(take), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .push_o(push), .rec_o(wrec)
  );

  crc_chk_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wrec), .full_o(full),
    .pop_i(pop), .valid_o(qv), .rdata_o(rrec)
  );

  crc_chk_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .q_valid_i(qv), .q_rec_i(rrec), .q_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

FILE: rtl/core/crc_chk_front.sv
// Front end: takes record bytes, decodes fields and runs both CRCs.
// Pushes one finished record summary per last byte. Uses crc_chk_pkg.
module crc_chk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                push_o,
  output crc_chk_pkg::rec_t   rec_o
);

  crc_chk_pkg::rec_t cur_q, cur_d, nxt;
  logic [16:0] q_off;
  logic [16:0] n_ext;
  logic [7:0]  h0, h1, h2;
  logic [10:0] hc;
  logic [23:0] fc;

  function automatic crc_chk_pkg::rec_t rec_clear();
    crc_chk_pkg::rec_t r;
    r = '0;
    r.run_fcrc = crc_chk_pkg::FcrcInit;
    return r;
  endfunction

  always_comb begin
    nxt   = cur_q;
    q_off = 17'({8'd0, cur_q.pos} - 17'd15);
    n_ext = {1'b0, cur_q.len};
    h0 = ((cur_q.flags & crc_chk_pkg::FlagMask) << 4) | {5'd0, cur_q.slot[10:8]};
    h1 = cur_q.slot[7:0];
    h2 = cur_q.len[8:1];
    hc = crc_chk_pkg::HcrcInit;
    fc = cur_q.run_fcrc;
    if (cur_q.pos != crc_chk_pkg::PosMax) begin
      nxt.pos = 9'(cur_q.pos + 9'd1);
      unique case (cur_q.pos)
        9'd0: nxt.channel = byte_i;
        9'd1: nxt.flags = byte_i;
        9'd2: nxt.cycle = byte_i;
        9'd3: nxt.slot = {byte_i, 8'd0};
        9'd4: nxt.slot = {cur_q.slot[15:8], byte_i};
        9'd5: nxt.len = {byte_i, 8'd0};
        9'd6: begin
          nxt.len = {cur_q.len[15:8], byte_i};
          h2 = nxt.len[8:1];
          hc = crc_chk_pkg::hcrc_byte(hc, h0);
          hc = crc_chk_pkg::hcrc_byte(hc, h1);
          hc = crc_chk_pkg::hcrc_byte(hc, h2);
          hc = crc_chk_pkg::hcrc_byte(hc, 8'd0);
          hc = crc_chk_pkg::hcrc_byte(hc, 8'd0);
          nxt.exp_hcrc = hc;
        end
        default: begin
          if (cur_q.pos < 9'd15) begin
            nxt.stamp = {cur_q.stamp[55:0], byte_i};
            if (cur_q.pos == 9'd7) begin
              fc = crc_chk_pkg::fcrc_byte(fc, h0);
              fc = crc_chk_pkg::fcrc_byte(fc, h1);
              fc = crc_chk_pkg::fcrc_byte(fc, h2);
              fc = crc_chk_pkg::fcrc_byte(fc, {5'd0, cur_q.exp_hcrc[10:8]});
              fc = crc_chk_pkg::fcrc_byte(fc, cur_q.exp_hcrc[7:0]);
              nxt.run_fcrc = fc;
            end
          end else if (q_off < n_ext) begin
            nxt.run_fcrc = crc_chk_pkg::fcrc_byte(fc, byte_i);
          end else if (q_off == n_ext) begin
            nxt.rcv_hcrc = {byte_i[2:0], 8'd0};
          end else if (q_off == n_ext + 17'd1) begin
            nxt.rcv_hcrc = {cur_q.rcv_hcrc[10:8], byte_i};
          end else if (q_off <= n_ext + 17'd4) begin
            nxt.rcv_fcrc = {cur_q.rcv_fcrc[15:0], byte_i};
          end
        end
      endcase
    end
    cur_d = cur_q;
    if (take_i) begin
      cur_d = last_i ? rec_clear() : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= rec_clear();
    end else begin
      cur_q <= cur_d;
    end
  end

  assign push_o = take_i && last_i;
  assign rec_o  = nxt;

endmodule

FILE: rtl/core/crc_chk_queue.sv
// Two-entry queue of record summaries between front and back end.
// Uses crc_chk_pkg and the assertion header.
`include "capture_record_checker_assert.svh"
module crc_chk_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crc_chk_pkg::rec_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output crc_chk_pkg::rec_t rdata_o
);

  crc_chk_pkg::rec_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push_i} - {1'b0, pop_i});
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `CRC_ASSERT(a_cnt_bound, cnt_q <= 2'd2)
  `CRC_NEVER(a_push_full, push_i && full_o)
  `CRC_NEVER(a_pop_empty, pop_i && !valid_o)

endmodule

FILE: rtl/core/crc_chk_back.sv
// Back end: checks a record summary, counts outcomes, holds the result item.
// Also holds the configuration registers. Uses crc_chk_pkg.
module crc_chk_back #(
  parameter int unsigned MAX_PAYLOAD = 254,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              q_valid_i,
  input  crc_chk_pkg::rec_t q_rec_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [263:0]      out_data_o
);

  localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD);

  logic [7:0]  max_pay_q;
  logic [11:0] slot_lim_q;
  logic [5:0]  max_cyc_q;
  logic [COUNT_BITS-1:0] cnt_q [4];
  logic [COUNT_BITS-1:0] cnt_d [4];
  logic        ov_q;
  logic [263:0] od_q, od_d;
  logic [15:0] limit;
  logic [16:0] exp_pos;
  crc_chk_pkg::status_e st;
  logic [1:0]  sel;
  crc_chk_pkg::rec_t r;

  assign r       = q_rec_i;
  assign q_pop_o = q_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    limit   = ({8'd0, max_pay_q} < MaxPay) ? {8'd0, max_pay_q} : MaxPay;
    exp_pos = 17'(crc_chk_pkg::FixedBytes) + {1'b0, r.len};
    if (r.pos < 9'(crc_chk_pkg::FixedBytes)) st = crc_chk_pkg::ST_SHORT;
    else if (r.len > limit || {8'd0, r.pos} != exp_pos) st = crc_chk_pkg::ST_BAD_LEN;
    else if (r.channel > 8'd1) st = crc_chk_pkg::ST_BAD_CHAN;
    else if (r.slot == 16'd0 || r.slot >= {4'd0, slot_lim_q}) st = crc_chk_pkg::ST_BAD_LEN;
    else if (r.cycle > {2'd0, max_cyc_q}) st = crc_chk_pkg::ST_BAD_LEN;
    else if (r.len[0]) st = crc_chk_pkg::ST_BAD_LEN;
    else if (r.exp_hcrc != r.rcv_hcrc) st = crc_chk_pkg::ST_HDR_CRC;
    else if (r.run_fcrc != r.rcv_fcrc) st = crc_chk_pkg::ST_FRAME_CRC;
    else st = crc_chk_pkg::ST_OK;
    unique case (st)
      crc_chk_pkg::ST_OK:        sel = 2'd0;
      crc_chk_pkg::ST_HDR_CRC:   sel = 2'd2;
      crc_chk_pkg::ST_FRAME_CRC: sel = 2'd3;
      default:                   sel = 2'd1;
    endcase
    for (int i = 0; i < 4; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    od_d = od_q;
    if (q_pop_o) begin
      cnt_d[sel] = cnt_q[sel] + COUNT_BITS'(1);
      od_d = {2'b00, 32'(cnt_d[3]), 32'(cnt_d[2]), 32'(cnt_d[1]), 32'(cnt_d[0]),
              r.rcv_hcrc, r.stamp, r.len, r.slot, r.cycle, r.flags, r.channel, st};
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q       <= 1'b0;
      max_pay_q  <= 8'd254;
      slot_lim_q <= 12'd2048;
      max_cyc_q  <= 6'd63;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
    end else begin
      ov_q <= q_pop_o || (ov_q && !out_ready_i);
      for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_d[i];
      if (cfg_valid_i) begin
        case (cfg_index_i)
          crc_chk_pkg::CFG_MAX_PAYLOAD: max_pay_q <= cfg_data_i[7:0];
          crc_chk_pkg::CFG_SLOT_LIMIT:  slot_lim_q <= cfg_data_i;
          crc_chk_pkg::CFG_MAX_CYCLE:   max_cyc_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule
